>>> rtl/core/segment_point_transform_unit_macros.svh
// ----------------------------------------------------------------------------
// segment point transform unit assertion macros
// concurrent assertion shorthands for the top level, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SEGMENT_POINT_TRANSFORM_UNIT_MACROS_SVH
`define SEGMENT_POINT_TRANSFORM_UNIT_MACROS_SVH

// condition implies property in the same cycle
`define SPT_ASSERT_SAME(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("assertion failed: label");

// condition implies property in the following cycle
`define SPT_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("assertion failed: label");

`endif

>>> rtl/core/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// shared types, constants and helper functions of the segment point transform
// ----------------------------------------------------------------------------
package spt_pkg;

	// default configuration
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// field and datapath widths
	localparam int OP_W     = 2;
	localparam int COORD_W  = 32;
	localparam int ANG_W    = 16;
	localparam int ZW       = 36;
	localparam int XW       = 34;
	localparam int TRIG_W   = 32;
	localparam int DIFF_W   = 33;
	localparam int PROD_W   = 65;
	localparam int SUM_W    = 67;
	localparam int ANG_SHIFT = 17;
	localparam int ROT_SHIFT = 28;

	// opcodes
	localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd0;
	localparam logic [OP_W-1:0] OP_ROTATE    = 2'd1;
	localparam logic [OP_W-1:0] OP_SCALE     = 2'd2;

	// cordic constants, q30
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

	typedef struct packed {
		logic [OP_W-1:0]           opcode;
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic signed [COORD_W-1:0] vector_x;
		logic signed [COORD_W-1:0] vector_y;
		logic signed [ANG_W-1:0]   turn_angle;
		logic signed [COORD_W-1:0] scale_factor;
	} spt_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] new_first_x;
		logic signed [COORD_W-1:0] new_first_y;
		logic signed [COORD_W-1:0] new_second_x;
		logic signed [COORD_W-1:0] new_second_y;
	} spt_out_t;

	// one endpoint with its operands, as handed to a lane
	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] k;
	} spt_point_t;

	// cosine and sine, q28
	typedef struct packed {
		logic signed [TRIG_W-1:0] cs;
		logic signed [TRIG_W-1:0] sn;
	} spt_trig_t;

	// atan(2^-i) * 2^30, floored up to i = 26, rounded to nearest above
	function automatic logic signed [ZW-1:0] atan_q30(input int idx);
		case (idx)
			0:  return 36'sh03243F6A8;
			1:  return 36'sh01DAC6705;
			2:  return 36'sh00FADBAFC;
			3:  return 36'sh007F56EA6;
			4:  return 36'sh003FEAB76;
			5:  return 36'sh001FFD55B;
			6:  return 36'sh000FFFAAA;
			7:  return 36'sh0007FFF55;
			8:  return 36'sh0003FFFEA;
			9:  return 36'sh0001FFFFD;
			10: return 36'sh0000FFFFF;
			11: return 36'sh00007FFFF;
			12: return 36'sh00003FFFF;
			13: return 36'sh00001FFFF;
			14: return 36'sh00000FFFF;
			15: return 36'sh000007FFF;
			16: return 36'sh000003FFF;
			17: return 36'sh000001FFF;
			18: return 36'sh000000FFF;
			19: return 36'sh0000007FF;
			20: return 36'sh0000003FF;
			21: return 36'sh0000001FF;
			22: return 36'sh0000000FF;
			23: return 36'sh00000007F;
			24: return 36'sh00000003F;
			25: return 36'sh00000001F;
			26: return 36'sh00000000F;
			27: return 36'sh000000008;
			28: return 36'sh000000004;
			29: return 36'sh000000002;
			30: return 36'sh000000001;
			default: return '0;
		endcase
	endfunction

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		if (v > $signed({{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}}))
			return {1'b0, {(COORD_W-1){1'b1}}};
		else if (v < $signed({{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}}))
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return v[COORD_W-1:0];
	endfunction

endpackage

>>> rtl/core/spt_cordic.sv
// ----------------------------------------------------------------------------
// spt_cordic
// pipelined rotation-mode cordic, one stage per iteration, q28 cos and sin
// ----------------------------------------------------------------------------
module spt_cordic #(
	parameter int STEPS = spt_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [spt_pkg::ANG_W-1:0]   angle,
	output spt_pkg::spt_trig_t                 trig
);
	import spt_pkg::*;

	logic signed [ZW-1:0] z_ext;
	logic signed [ZW-1:0] z_pre;
	logic                 flip_pre;

	logic signed [XW-1:0] x_s [STEPS+1];
	logic signed [XW-1:0] y_s [STEPS+1];
	logic signed [ZW-1:0] z_s [STEPS+1];
	logic                 flip_s [STEPS+1];

	logic signed [XW-1:0] xf, yf, xr, yr;
	spt_trig_t            trig_q;

	// widen the angle to q30 and fold it into plus or minus a right angle
	always_comb begin
		z_ext    = ZW'(angle) <<< ANG_SHIFT;
		z_pre    = z_ext;
		flip_pre = 1'b0;
		if (z_ext > HALF_PI_Q30) begin
			z_pre    = z_ext - PI_Q30;
			flip_pre = 1'b1;
		end else if (z_ext < -HALF_PI_Q30) begin
			z_pre    = z_ext + PI_Q30;
			flip_pre = 1'b1;
		end
	end

	// entry stage
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= GAIN_Q30;
			y_s[0]    <= '0;
			z_s[0]    <= z_pre;
			flip_s[0] <= flip_pre;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end
			end
		end
	end

	// undo the fold, then round half up from q30 to q28
	always_comb begin
		xf = flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
		yf = flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
		xr = (xf >>> 2) + $signed({{(XW-1){1'b0}}, xf[1]});
		yr = (yf >>> 2) + $signed({{(XW-1){1'b0}}, yf[1]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_q.cs <= xr[TRIG_W-1:0];
			trig_q.sn <= yr[TRIG_W-1:0];
		end
	end

	assign trig = trig_q;

endmodule

>>> rtl/core/spt_lane.sv
// ----------------------------------------------------------------------------
// spt_lane
// transforms one endpoint: translate, rotate about pivot or scale about center
// ----------------------------------------------------------------------------
module spt_lane #(
	parameter int FRAC = spt_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  spt_pkg::spt_point_t                  pt,
	input  spt_pkg::spt_trig_t                   trig,
	output logic signed [spt_pkg::COORD_W-1:0]   rx,
	output logic signed [spt_pkg::COORD_W-1:0]   ry
);
	import spt_pkg::*;

	logic [OP_W-1:0]           op_s1, op_s2;
	logic signed [COORD_W-1:0] px_s1, py_s1, cx_s1, cy_s1, k_s1, tx_s1, ty_s1;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1;
	logic signed [COORD_W-1:0] px_s2, py_s2, cx_s2, cy_s2, tx_s2, ty_s2;
	logic signed [PROD_W-1:0]  pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [COORD_W-1:0] bx;

	logic signed [SUM_W-1:0] rot_x, rot_y, rot_xs, rot_ys, rot_xr, rot_yr;
	logic signed [SUM_W-1:0] scl_xs, scl_ys, scl_xr, scl_yr;

	// stage 1: differences and the translated point
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= pt.op;
			px_s1 <= pt.px;
			py_s1 <= pt.py;
			cx_s1 <= pt.cx;
			cy_s1 <= pt.cy;
			k_s1  <= pt.k;
			tx_s1 <= sat32(SUM_W'(pt.px) + SUM_W'(pt.cx));
			ty_s1 <= sat32(SUM_W'(pt.py) + SUM_W'(pt.cy));
			if (pt.op == OP_ROTATE) begin
				dx_s1 <= DIFF_W'(pt.px) - DIFF_W'(pt.cx);
				dy_s1 <= DIFF_W'(pt.py) - DIFF_W'(pt.cy);
			end else begin
				dx_s1 <= DIFF_W'(pt.cx) - DIFF_W'(pt.px);
				dy_s1 <= DIFF_W'(pt.cy) - DIFF_W'(pt.py);
			end
		end
	end

	// stage 2: products, the diagonal pair shared by rotate and scale
	assign bx = (op_s1 == OP_ROTATE) ? trig.cs : k_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			tx_s2 <= tx_s1;
			ty_s2 <= ty_s1;
			pa_s2 <= PROD_W'(dx_s1) * PROD_W'(bx);
			pb_s2 <= PROD_W'(dy_s1) * PROD_W'(trig.sn);
			pc_s2 <= PROD_W'(dx_s1) * PROD_W'(trig.sn);
			pd_s2 <= PROD_W'(dy_s1) * PROD_W'(bx);
		end
	end

	// stage 3: combine, round half up, offset and saturate
	always_comb begin
		rot_x  = SUM_W'(pa_s2) - SUM_W'(pb_s2);
		rot_y  = SUM_W'(pc_s2) + SUM_W'(pd_s2);
		rot_xs = rot_x >>> ROT_SHIFT;
		rot_ys = rot_y >>> ROT_SHIFT;
		rot_xr = rot_xs + $signed({{(SUM_W-1){1'b0}}, rot_x[ROT_SHIFT-1]});
		rot_yr = rot_ys + $signed({{(SUM_W-1){1'b0}}, rot_y[ROT_SHIFT-1]});
		scl_xs = SUM_W'(pa_s2) >>> FRAC;
		scl_ys = SUM_W'(pd_s2) >>> FRAC;
		scl_xr = scl_xs + $signed({{(SUM_W-1){1'b0}}, pa_s2[FRAC-1]});
		scl_yr = scl_ys + $signed({{(SUM_W-1){1'b0}}, pd_s2[FRAC-1]});
		case (op_s2)
			OP_TRANSLATE: begin
				rx = tx_s2;
				ry = ty_s2;
			end
			OP_ROTATE: begin
				rx = sat32(SUM_W'(cx_s2) + rot_xr);
				ry = sat32(SUM_W'(cy_s2) + rot_yr);
			end
			OP_SCALE: begin
				rx = sat32(SUM_W'(px_s2) + scl_xr);
				ry = sat32(SUM_W'(py_s2) + scl_yr);
			end
			default: begin
				rx = px_s2;
				ry = py_s2;
			end
		endcase
	end

endmodule

>>> rtl/core/segment_point_transform_unit.sv
// ----------------------------------------------------------------------------
// segment_point_transform_unit
// applies translate, rotate or scale to both endpoints of a line segment
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid / in_ready / in_data carries one segment, opcode
//   and operands per transaction; output channel out_valid / out_ready /
//   out_data returns the two transformed endpoints, one result per input.
// path: from accept to out_valid an item runs through the cordic pipeline
//   (entry register, one register per iteration, rounding register),
//   followed by the endpoint lanes' multiply stage and the output
//   register.
// throughput: one transaction per cycle unless the output stalls; every item runs through the same
//   fixed-depth pipeline whatever its opcode.
// reset: arst_n clears all valid flags; the pipeline comes up empty and
//   in_ready is high.
// stall: while out_valid is high and out_ready low, the whole pipeline holds
//   and in_ready drops; nothing is dropped and no bubble is added.
// ----------------------------------------------------------------------------
module segment_point_transform_unit #(
	parameter int FRAC_BITS    = spt_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = spt_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spt_pkg::spt_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output spt_pkg::spt_out_t out_data
);
	import spt_pkg::*;

	`include "segment_point_transform_unit_macros.svh"

	localparam int DLY     = CORDIC_STEPS + 1;
	localparam int VLD_LEN = CORDIC_STEPS + 3;

	logic       en;
	spt_in_t    dly_q [DLY];
	logic       vld_q [VLD_LEN];
	logic       out_valid_q;
	spt_out_t   out_data_q;
	spt_in_t    d;
	spt_point_t pt_a, pt_b;
	spt_trig_t  trig;
	logic signed [COORD_W-1:0] ax, ay, bx, by;

	// the pipeline advances whenever the output register can move
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// valid flags along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VLD_LEN; i++) vld_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < VLD_LEN; i++) vld_q[i] <= vld_q[i-1];
			out_valid_q <= vld_q[VLD_LEN-1];
		end
	end

	// operands wait alongside the cordic
	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= in_data;
			for (int i = 1; i < DLY; i++) dly_q[i] <= dly_q[i-1];
		end
	end

	spt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk   (clk),
		.en    (en),
		.angle (in_data.turn_angle),
		.trig  (trig)
	);

	// one lane per endpoint
	assign d    = dly_q[DLY-1];
	assign pt_a = '{op: d.opcode, px: d.first_x, py: d.first_y,
		cx: d.vector_x, cy: d.vector_y, k: d.scale_factor};
	assign pt_b = '{op: d.opcode, px: d.second_x, py: d.second_y,
		cx: d.vector_x, cy: d.vector_y, k: d.scale_factor};

	spt_lane #(.FRAC(FRAC_BITS)) u_lane_a (
		.clk  (clk),
		.en   (en),
		.pt   (pt_a),
		.trig (trig),
		.rx   (ax),
		.ry   (ay)
	);

	spt_lane #(.FRAC(FRAC_BITS)) u_lane_b (
		.clk  (clk),
		.en   (en),
		.pt   (pt_b),
		.trig (trig),
		.rx   (bx),
		.ry   (by)
	);

	// merge both lanes into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.new_first_x  <= ax;
			out_data_q.new_first_y  <= ay;
			out_data_q.new_second_x <= bx;
			out_data_q.new_second_y <= by;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	`SPT_ASSERT_SAME(a_stall_only_when_full, !in_ready, out_valid_q)
	`SPT_ASSERT_NEXT(a_accept_enters_pipe, in_valid && in_ready, vld_q[0])
	`SPT_ASSERT_NEXT(a_stall_holds_last, !in_ready, $stable(vld_q[VLD_LEN-1]))

endmodule
